/* hw/rtl/dfgc_pkg.sv */
// ----------------------------------------------------------------------------
// dfgc_pkg
// Shared types, constants and helpers for the diamond face gradient block.
// ----------------------------------------------------------------------------
package dfgc_pkg;

    localparam int QW = 32;              // Q16.16 word
    localparam int PW = 2 * QW;          // exact product, Q32.32
    localparam int AREA_SHR = 17;        // /2 of the cross product, back to Q16.16
    localparam int DIV_LAT = QW + 2;     // range check, QW steps, sign/saturate
    localparam int FRONT_LAT = 5;        // point, diffs, products, cross, magnitude

    localparam logic [2:0] KIND_INTERIOR = 3'd0;
    localparam logic [2:0] KIND_PER_X    = 3'd1;
    localparam logic [2:0] KIND_PER_Y    = 3'd2;
    localparam logic [2:0] KIND_HALO     = 3'd3;
    localparam logic [2:0] KIND_GHOST    = 3'd4;

    typedef logic signed [QW-1:0] t_q;
    typedef logic signed [PW-1:0] t_p;

    localparam t_q Q_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam t_q Q_MIN = {1'b1, {(QW-1){1'b0}}};

    typedef struct packed {
        logic [2:0] source_kind;
        t_q node1_x;
        t_q node1_y;
        t_q node2_x;
        t_q node2_y;
        t_q left_x;
        t_q left_y;
        t_q other_x;
        t_q other_y;
        t_q shift;
        t_q normal_x;
        t_q normal_y;
    } t_in;

    typedef struct packed {
        t_q   f1_x;
        t_q   f1_y;
        t_q   f2_x;
        t_q   f2_y;
        t_q   f3_x;
        t_q   f3_y;
        t_q   area;
        t_q   param1;
        t_q   param2;
        t_q   param3;
        t_q   param4;
        logic degenerate;
    } t_out;

    typedef struct packed {
        t_q n1x;
        t_q n1y;
        t_q n2x;
        t_q n2y;
        t_q lx;
        t_q ly;
        t_q vx;
        t_q vy;
        t_q nx;
        t_q ny;
    } t_pts;

    typedef struct packed {
        t_q f1x;
        t_q f1y;
        t_q f2x;
        t_q f2y;
        t_q f3x;
        t_q f3y;
        t_q area;
        logic degen;
    } t_side;

    function automatic t_q sat33(input logic signed [QW:0] s);
        t_q r;
        if (s[QW] != s[QW-1]) begin
            r = s[QW] ? Q_MIN : Q_MAX;
        end else begin
            r = s[QW-1:0];
        end
        return r;
    endfunction

    function automatic t_q sat_add(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} + {b[QW-1], b};
        return sat33(s);
    endfunction

    function automatic t_q sat_sub(input t_q a, input t_q b);
        logic signed [QW:0] s;
        s = {a[QW-1], a} - {b[QW-1], b};
        return sat33(s);
    endfunction

endpackage

/* hw/rtl/dfgc_in_if.sv */
// ----------------------------------------------------------------------------
// dfgc_in_if
// Face item channel: valid/ready with the gathered face values.
// ----------------------------------------------------------------------------
interface dfgc_in_if;
    logic           valid;
    logic           ready;
    dfgc_pkg::t_in  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dfgc_out_if.sv */
// ----------------------------------------------------------------------------
// dfgc_out_if
// Result item channel: valid/ready with edge vectors, area and coefficients.
// ----------------------------------------------------------------------------
interface dfgc_out_if;
    logic           valid;
    logic           ready;
    dfgc_pkg::t_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dfgc_div.sv */
// ----------------------------------------------------------------------------
// dfgc_div
// Pipelined signed divide num / den, truncated and saturated to Q range.
// Magnitude in, one quotient bit per stage, zero forced on a degenerate face.
// ----------------------------------------------------------------------------
module dfgc_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [dfgc_pkg::PW-1:0]   i_num,
    input  logic [dfgc_pkg::QW:0]     i_den,
    input  logic                      i_neg,
    input  logic                      i_zero,
    output dfgc_pkg::t_q              o_q
);

    localparam int QW = dfgc_pkg::QW;
    localparam int PW = dfgc_pkg::PW;

    logic [PW-1:0] r_rem  [0:QW];
    logic [QW-1:0] r_quo  [0:QW];
    logic [QW:0]   r_den  [0:QW];
    logic [QW:0]   r_ovf;
    logic [QW:0]   r_neg;
    logic [QW:0]   r_zero;
    dfgc_pkg::t_q  r_q;
    dfgc_pkg::t_q  n_q;

    // quotient would not fit in QW bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_num;
            r_quo[0]  <= '0;
            r_den[0]  <= i_den;
            r_ovf[0]  <= {1'b0, i_num[PW-1:QW]} >= i_den;
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [PW-1:0] w_sub;
        assign w_sub = {{(PW-QW-1){1'b0}}, r_den[k-1]} << B;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_rem[k-1] >= w_sub) begin
                    r_rem[k]    <= r_rem[k-1] - w_sub;
                    r_quo[k]    <= r_quo[k-1] | (QW'(1) << B);
                end else begin
                    r_rem[k]    <= r_rem[k-1];
                    r_quo[k]    <= r_quo[k-1];
                end
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    always_comb begin
        if (r_zero[QW]) begin
            n_q = '0;
        end else if (r_neg[QW]) begin
            if (r_ovf[QW] || (r_quo[QW][QW-1] && (r_quo[QW][QW-2:0] != '0))) begin
                n_q = dfgc_pkg::Q_MIN;
            end else begin
                n_q = dfgc_pkg::t_q'(QW'(0) - r_quo[QW]);
            end
        end else begin
            if (r_ovf[QW] || r_quo[QW][QW-1]) begin
                n_q = dfgc_pkg::Q_MAX;
            end else begin
                n_q = dfgc_pkg::t_q'(r_quo[QW]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

/* hw/rtl/diamond_face_gradient_coeffs.sv */
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Depth is set by the four parallel bit-per-stage dividers (34 stages).
// Reset (synchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// diamond_face_gradient_coeffs
// Diamond edge vectors, signed area and four gradient coefficients per face.
// ----------------------------------------------------------------------------
module diamond_face_gradient_coeffs (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfgc_in_if.sink    i_in,
    dfgc_out_if.source o_out
);

    localparam int QW = dfgc_pkg::QW;
    localparam int PW = dfgc_pkg::PW;
    localparam int NS = dfgc_pkg::FRONT_LAT + dfgc_pkg::DIV_LAT;
    localparam int DL = dfgc_pkg::DIV_LAT;

    logic             w_en;
    logic [NS-1:0]    r_vld;

    dfgc_pkg::t_pts   r_s1;
    dfgc_pkg::t_pts   n_s1;

    dfgc_pkg::t_side  r_s2_side;
    dfgc_pkg::t_q     r_s2_ax [4];
    dfgc_pkg::t_q     r_s2_ay [4];
    dfgc_pkg::t_q     r_s2_nx;
    dfgc_pkg::t_q     r_s2_ny;

    dfgc_pkg::t_side  r_s3_side;
    dfgc_pkg::t_p     r_s3_pa;
    dfgc_pkg::t_p     r_s3_pb;
    dfgc_pkg::t_p     r_s3_py [4];
    dfgc_pkg::t_p     r_s3_px [4];

    dfgc_pkg::t_side  r_s4_side;
    dfgc_pkg::t_p     r_s4_cross;
    dfgc_pkg::t_p     r_s4_num [4];

    dfgc_pkg::t_side  r_s5_side;
    logic [QW:0]      r_s5_den;
    logic [PW-1:0]    r_s5_mag [4];
    logic [3:0]       r_s5_neg;

    dfgc_pkg::t_side  r_side [0:DL-1];
    dfgc_pkg::t_q     w_q [4];

    dfgc_pkg::t_p     w_shr;
    dfgc_pkg::t_q     w_area;
    logic [QW:0]      w_aext;
    logic [QW:0]      w_aabs;

    assign w_en = !r_vld[NS-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_in.valid};
        end
    end

    // stage 1: other-side point
    always_comb begin
        n_s1.n1x = i_in.data.node1_x;
        n_s1.n1y = i_in.data.node1_y;
        n_s1.n2x = i_in.data.node2_x;
        n_s1.n2y = i_in.data.node2_y;
        n_s1.lx  = i_in.data.left_x;
        n_s1.ly  = i_in.data.left_y;
        n_s1.nx  = i_in.data.normal_x;
        n_s1.ny  = i_in.data.normal_y;
        case (i_in.data.source_kind) inside
            dfgc_pkg::KIND_INTERIOR, dfgc_pkg::KIND_HALO, dfgc_pkg::KIND_GHOST: begin
                n_s1.vx = i_in.data.other_x;
                n_s1.vy = i_in.data.other_y;
            end
            dfgc_pkg::KIND_PER_X: begin
                n_s1.vx = dfgc_pkg::sat_add(i_in.data.other_x, i_in.data.shift);
                n_s1.vy = i_in.data.other_y;
            end
            dfgc_pkg::KIND_PER_Y: begin
                n_s1.vx = i_in.data.other_x;
                n_s1.vy = dfgc_pkg::sat_add(i_in.data.other_y, i_in.data.shift);
            end
            default: begin
                n_s1.vx = '0;
                n_s1.vy = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1 <= n_s1;
        end
    end

    // stage 2: saturated differences
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_side.f1x  <= dfgc_pkg::sat_sub(r_s1.lx, r_s1.n1x);
            r_s2_side.f1y  <= dfgc_pkg::sat_sub(r_s1.ly, r_s1.n1y);
            r_s2_side.f2x  <= dfgc_pkg::sat_sub(r_s1.n2x, r_s1.lx);
            r_s2_side.f2y  <= dfgc_pkg::sat_sub(r_s1.n2y, r_s1.ly);
            r_s2_side.f3x  <= dfgc_pkg::sat_sub(r_s1.vx, r_s1.n2x);
            r_s2_side.f3y  <= dfgc_pkg::sat_sub(r_s1.vy, r_s1.n2y);
            r_s2_side.area <= '0;
            r_s2_side.degen <= 1'b0;
            r_s2_ax[0] <= dfgc_pkg::sat_sub(r_s1.n2x, r_s1.n1x);
            r_s2_ay[0] <= dfgc_pkg::sat_sub(r_s1.n2y, r_s1.n1y);
            r_s2_ax[1] <= dfgc_pkg::sat_sub(r_s1.vx, r_s1.lx);
            r_s2_ay[1] <= dfgc_pkg::sat_sub(r_s1.vy, r_s1.ly);
            r_s2_ax[2] <= dfgc_pkg::sat_sub(r_s1.n1x, r_s1.n2x);
            r_s2_ay[2] <= dfgc_pkg::sat_sub(r_s1.n1y, r_s1.n2y);
            r_s2_ax[3] <= dfgc_pkg::sat_sub(r_s1.lx, r_s1.vx);
            r_s2_ay[3] <= dfgc_pkg::sat_sub(r_s1.ly, r_s1.vy);
            r_s2_nx <= r_s1.nx;
            r_s2_ny <= r_s1.ny;
        end
    end

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3_side <= r_s2_side;
            r_s3_pa   <= dfgc_pkg::t_p'(r_s2_ax[0]) * dfgc_pkg::t_p'(r_s2_ay[1]);
            r_s3_pb   <= dfgc_pkg::t_p'(r_s2_ax[1]) * dfgc_pkg::t_p'(r_s2_ay[0]);
            for (int i = 0; i < 4; i++) begin
                r_s3_py[i] <= dfgc_pkg::t_p'(r_s2_ay[i]) * dfgc_pkg::t_p'(r_s2_nx);
                r_s3_px[i] <= dfgc_pkg::t_p'(r_s2_ax[i]) * dfgc_pkg::t_p'(r_s2_ny);
            end
        end
    end

    // stage 4: cross products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_side  <= r_s3_side;
            r_s4_cross <= r_s3_pa - r_s3_pb;
            for (int i = 0; i < 4; i++) begin
                r_s4_num[i] <= r_s3_py[i] - r_s3_px[i];
            end
        end
    end

    // stage 5: area, divisor and numerator magnitudes
    always_comb begin
        w_shr = r_s4_cross >>> dfgc_pkg::AREA_SHR;
        if (w_shr > PW'(dfgc_pkg::Q_MAX)) begin
            w_area = dfgc_pkg::Q_MAX;
        end else if (w_shr < PW'(dfgc_pkg::Q_MIN)) begin
            w_area = dfgc_pkg::Q_MIN;
        end else begin
            w_area = w_shr[QW-1:0];
        end
        w_aext = {w_area[QW-1], w_area};
        w_aabs = w_area[QW-1] ? (QW+1)'(0) - w_aext : w_aext;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_side.f1x   <= r_s4_side.f1x;
            r_s5_side.f1y   <= r_s4_side.f1y;
            r_s5_side.f2x   <= r_s4_side.f2x;
            r_s5_side.f2y   <= r_s4_side.f2y;
            r_s5_side.f3x   <= r_s4_side.f3x;
            r_s5_side.f3y   <= r_s4_side.f3y;
            r_s5_side.area  <= w_area;
            r_s5_side.degen <= (w_area == '0);
            r_s5_den        <= {w_aabs[QW-1:0], 1'b0};
            for (int i = 0; i < 4; i++) begin
                r_s5_mag[i] <= r_s4_num[i][PW-1] ? PW'(0) - r_s4_num[i] : r_s4_num[i];
                r_s5_neg[i] <= r_s4_num[i][PW-1] ^ w_area[QW-1];
            end
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_lane
        dfgc_div u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_s5_mag[i]),
            .i_den  (r_s5_den),
            .i_neg  (r_s5_neg[i]),
            .i_zero (r_s5_side.degen),
            .o_q    (w_q[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= r_s5_side;
            for (int k = 1; k < DL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    assign o_out.valid           = r_vld[NS-1];
    assign o_out.data.f1_x       = r_side[DL-1].f1x;
    assign o_out.data.f1_y       = r_side[DL-1].f1y;
    assign o_out.data.f2_x       = r_side[DL-1].f2x;
    assign o_out.data.f2_y       = r_side[DL-1].f2y;
    assign o_out.data.f3_x       = r_side[DL-1].f3x;
    assign o_out.data.f3_y       = r_side[DL-1].f3y;
    assign o_out.data.area       = r_side[DL-1].area;
    assign o_out.data.degenerate = r_side[DL-1].degen;
    assign o_out.data.param1     = w_q[0];
    assign o_out.data.param2     = w_q[1];
    assign o_out.data.param3     = w_q[2];
    assign o_out.data.param4     = w_q[3];

endmodule

/* tb/diamond_face_gradient_coeffs_tb.sv */
// ----------------------------------------------------------------------------
// diamond_face_gradient_coeffs_tb
// Streams face items through the block under random valid/ready idling and
// one long output hold-off; each result is checked against a local model or a hand-written result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module diamond_face_gradient_coeffs_tb;

    localparam int N_RANDOM = 730;
    localparam int N_DIRECTED = 16;

    logic clk;
    logic rst_n;
    int   errors = 0;
    int   n_results = 0;
    bit   stim_done = 0;

    dfgc_pkg::t_out expected_q[$];

    dfgc_in_if  in_ch();
    dfgc_out_if out_ch();

    diamond_face_gradient_coeffs dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic longint grad_coeff(input longint ax, input longint ay,
                                          input longint nx, input longint ny,
                                          input longint ar);
        longint num;
        num = ay * nx - ax * ny;
        return clamp32(num / (2 * ar));
    endfunction

    function automatic dfgc_pkg::t_out face_coeffs(input dfgc_pkg::t_in f);
        longint n1x, n1y, n2x, n2y, lx, ly, vx, vy, nx, ny;
        longint dnx, dny, dvx, dvy, ar;
        dfgc_pkg::t_out r;
        n1x = longint'(f.node1_x); n1y = longint'(f.node1_y);
        n2x = longint'(f.node2_x); n2y = longint'(f.node2_y);
        lx  = longint'(f.left_x);  ly  = longint'(f.left_y);
        nx  = longint'(f.normal_x); ny = longint'(f.normal_y);
        vx = 0;
        vy = 0;
        case (f.source_kind) inside
            dfgc_pkg::KIND_INTERIOR, dfgc_pkg::KIND_HALO, dfgc_pkg::KIND_GHOST: begin
                vx = longint'(f.other_x);
                vy = longint'(f.other_y);
            end
            dfgc_pkg::KIND_PER_X: begin
                vx = clamp32(longint'(f.other_x) + longint'(f.shift));
                vy = longint'(f.other_y);
            end
            dfgc_pkg::KIND_PER_Y: begin
                vx = longint'(f.other_x);
                vy = clamp32(longint'(f.other_y) + longint'(f.shift));
            end
            default: begin
            end
        endcase
        dnx = clamp32(n2x - n1x);
        dny = clamp32(n2y - n1y);
        dvx = clamp32(vx - lx);
        dvy = clamp32(vy - ly);
        ar = clamp32((dnx * dvy - dvx * dny) >>> dfgc_pkg::AREA_SHR);
        r = '0;
        r.f1_x = dfgc_pkg::t_q'(clamp32(lx - n1x));
        r.f1_y = dfgc_pkg::t_q'(clamp32(ly - n1y));
        r.f2_x = dfgc_pkg::t_q'(clamp32(n2x - lx));
        r.f2_y = dfgc_pkg::t_q'(clamp32(n2y - ly));
        r.f3_x = dfgc_pkg::t_q'(clamp32(vx - n2x));
        r.f3_y = dfgc_pkg::t_q'(clamp32(vy - n2y));
        r.area = dfgc_pkg::t_q'(ar);
        r.degenerate = (ar == 0);
        if (ar != 0) begin
            r.param1 = dfgc_pkg::t_q'(grad_coeff(dnx, dny, nx, ny, ar));
            r.param2 = dfgc_pkg::t_q'(grad_coeff(dvx, dvy, nx, ny, ar));
            r.param3 = dfgc_pkg::t_q'(grad_coeff(clamp32(n1x - n2x), clamp32(n1y - n2y),
                                                 nx, ny, ar));
            r.param4 = dfgc_pkg::t_q'(grad_coeff(clamp32(lx - vx), clamp32(ly - vy),
                                                 nx, ny, ar));
        end
        return r;
    endfunction

    function automatic dfgc_pkg::t_q rand_coord(input int mode);
        case (mode)
            0:       return dfgc_pkg::t_q'($urandom);
            1:       return $urandom_range(1, 0)
                         ? dfgc_pkg::Q_MAX - dfgc_pkg::t_q'($urandom_range(0, 255))
                         : dfgc_pkg::Q_MIN + dfgc_pkg::t_q'($urandom_range(0, 255));
            2:       return dfgc_pkg::t_q'($urandom_range(0, 255)) - 128;
            default: return dfgc_pkg::t_q'($urandom_range(0, 2 ** 22)) - (2 ** 21);
        endcase
    endfunction

    function automatic dfgc_pkg::t_in rand_face();
        dfgc_pkg::t_in f;
        int  mode;
        mode = ($urandom_range(0, 9) < 2) ? $urandom_range(0, 2) : 3;
        f.source_kind = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                     : 3'($urandom_range(0, 5));
        f.node1_x  = rand_coord(mode);
        f.node1_y  = rand_coord(mode);
        f.node2_x  = rand_coord(mode);
        f.node2_y  = rand_coord(mode);
        f.left_x   = rand_coord(mode);
        f.left_y   = rand_coord(mode);
        f.other_x  = rand_coord(mode);
        f.other_y  = rand_coord(mode);
        f.shift    = rand_coord(mode);
        f.normal_x = rand_coord($urandom_range(0, 3));
        f.normal_y = rand_coord($urandom_range(0, 3));
        if ($urandom_range(0, 19) == 0) begin
            f.other_x = f.left_x;
            f.other_y = f.left_y;
            f.source_kind = dfgc_pkg::KIND_INTERIOR;
        end
        return f;
    endfunction

    // directed rows; has_exp marks rows with a hand-written result
    dfgc_pkg::t_in  dir_face[N_DIRECTED];
    dfgc_pkg::t_out dir_exp[N_DIRECTED];
    bit             dir_has_exp[N_DIRECTED];

    task automatic build_directed();
        dfgc_pkg::t_in base;
        base = '0;
        base.node1_x = 32'sh0000_0000; base.node1_y = 32'sh0000_0000;
        base.node2_x = 32'sh0001_0000; base.node2_y = 32'sh0000_0000;
        base.left_x  = 32'sh0000_8000; base.left_y  = -32'sh0000_8000;
        base.other_x = 32'sh0000_8000; base.other_y = 32'sh0000_8000;
        base.shift   = 32'sh0002_0000;
        base.normal_x = 32'sh0000_0000; base.normal_y = -32'sh0001_0000;
        for (int i = 0; i < N_DIRECTED; i++) begin
            dir_face[i] = base;
            dir_has_exp[i] = 1'b0;
            dir_exp[i] = '0;
        end
        // all zero: degenerate, everything zero
        dir_face[0] = '0;
        dir_has_exp[0] = 1'b1;
        dir_exp[0].degenerate = 1'b1;
        // all points at the positive extreme: degenerate
        dir_face[1] = '{source_kind: dfgc_pkg::KIND_INTERIOR,
                        node1_x: dfgc_pkg::Q_MAX, node1_y: dfgc_pkg::Q_MAX,
                        node2_x: dfgc_pkg::Q_MAX, node2_y: dfgc_pkg::Q_MAX,
                        left_x: dfgc_pkg::Q_MAX, left_y: dfgc_pkg::Q_MAX,
                        other_x: dfgc_pkg::Q_MAX, other_y: dfgc_pkg::Q_MAX,
                        shift: dfgc_pkg::Q_MAX,
                        normal_x: dfgc_pkg::Q_MAX, normal_y: dfgc_pkg::Q_MAX};
        dir_has_exp[1] = 1'b1;
        dir_exp[1].degenerate = 1'b1;
        // each kind, including the undefined ones
        for (int k = 0; k < 8; k++) begin
            dir_face[2 + k].source_kind = 3'(k);
        end
        // periodic shifts that saturate
        dir_face[10].source_kind = dfgc_pkg::KIND_PER_X;
        dir_face[10].other_x = dfgc_pkg::Q_MAX;
        dir_face[10].shift = dfgc_pkg::Q_MAX;
        dir_face[11].source_kind = dfgc_pkg::KIND_PER_Y;
        dir_face[11].other_y = dfgc_pkg::Q_MIN;
        dir_face[11].shift = dfgc_pkg::Q_MIN;
        // opposite extremes: saturated differences and area
        dir_face[12] = '{source_kind: dfgc_pkg::KIND_HALO,
                         node1_x: dfgc_pkg::Q_MIN, node1_y: dfgc_pkg::Q_MAX,
                         node2_x: dfgc_pkg::Q_MAX, node2_y: dfgc_pkg::Q_MIN,
                         left_x: dfgc_pkg::Q_MIN, left_y: dfgc_pkg::Q_MIN,
                         other_x: dfgc_pkg::Q_MAX, other_y: dfgc_pkg::Q_MAX,
                         shift: dfgc_pkg::Q_MIN,
                         normal_x: dfgc_pkg::Q_MIN, normal_y: dfgc_pkg::Q_MAX};
        dir_face[13] = '{source_kind: dfgc_pkg::KIND_GHOST,
                         node1_x: dfgc_pkg::Q_MAX, node1_y: dfgc_pkg::Q_MIN,
                         node2_x: dfgc_pkg::Q_MIN, node2_y: dfgc_pkg::Q_MAX,
                         left_x: dfgc_pkg::Q_MAX, left_y: dfgc_pkg::Q_MIN,
                         other_x: dfgc_pkg::Q_MIN, other_y: dfgc_pkg::Q_MAX,
                         shift: dfgc_pkg::Q_MAX,
                         normal_x: dfgc_pkg::Q_MAX, normal_y: dfgc_pkg::Q_MIN};
        // tiny true area that floors to zero or to minus one
        dir_face[14].node2_x = 32'sd1;
        dir_face[14].other_y = -32'sh0000_8000 + 32'sd1;
        dir_face[15].node2_x = -32'sd1;
        dir_face[15].other_y = -32'sh0000_8000 + 32'sd1;
        dir_face[15].normal_x = dfgc_pkg::Q_MAX;
    endtask

    task automatic check_result(input dfgc_pkg::t_out exp, input dfgc_pkg::t_out act);
        if (act.f1_x !== exp.f1_x) begin
            $error("f1_x exp %0d got %0d", exp.f1_x, act.f1_x); errors++;
        end
        if (act.f1_y !== exp.f1_y) begin
            $error("f1_y exp %0d got %0d", exp.f1_y, act.f1_y); errors++;
        end
        if (act.f2_x !== exp.f2_x) begin
            $error("f2_x exp %0d got %0d", exp.f2_x, act.f2_x); errors++;
        end
        if (act.f2_y !== exp.f2_y) begin
            $error("f2_y exp %0d got %0d", exp.f2_y, act.f2_y); errors++;
        end
        if (act.f3_x !== exp.f3_x) begin
            $error("f3_x exp %0d got %0d", exp.f3_x, act.f3_x); errors++;
        end
        if (act.f3_y !== exp.f3_y) begin
            $error("f3_y exp %0d got %0d", exp.f3_y, act.f3_y); errors++;
        end
        if (act.area !== exp.area) begin
            $error("area exp %0d got %0d", exp.area, act.area); errors++;
        end
        if (act.param1 !== exp.param1) begin
            $error("param1 exp %0d got %0d", exp.param1, act.param1); errors++;
        end
        if (act.param2 !== exp.param2) begin
            $error("param2 exp %0d got %0d", exp.param2, act.param2); errors++;
        end
        if (act.param3 !== exp.param3) begin
            $error("param3 exp %0d got %0d", exp.param3, act.param3); errors++;
        end
        if (act.param4 !== exp.param4) begin
            $error("param4 exp %0d got %0d", exp.param4, act.param4); errors++;
        end
        if (act.degenerate !== exp.degenerate) begin
            $error("degenerate exp %0d got %0d", exp.degenerate, act.degenerate);
            errors++;
        end
    endtask

    task automatic send_face(input dfgc_pkg::t_in f, input dfgc_pkg::t_out exp,
                             input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= f;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        expected_q.push_back(exp);
    endtask

    function automatic int draw_gap(input bit busy);
        return busy ? 0 : $urandom_range(0, 9);
    endfunction

    // sender
    initial begin
        dfgc_pkg::t_in f;
        bit  busy;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        rst_n <= 1'b0;
        build_directed();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++) begin
            send_face(dir_face[i], dir_has_exp[i] ? dir_exp[i] : face_coeffs(dir_face[i]),
                      draw_gap(1'b0));
        end
        busy = 1'b0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0) begin
                busy = ($urandom_range(0, 2) == 0);
            end
            f = rand_face();
            send_face(f, face_coeffs(f), draw_gap(busy));
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver, with one long hold-off while the sender keeps pushing
    initial begin
        int stall;
        bit held;
        dfgc_pkg::t_out exp;
        out_ch.ready <= 1'b0;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held && n_results == 60) begin
                stall = 400;
                held = 1'b1;
            end else begin
                stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result item with no face pending");
                errors++;
            end else begin
                exp = expected_q.pop_front();
                check_result(exp, out_ch.data);
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/dfgc_pkg.sv
hw/rtl/dfgc_in_if.sv
hw/rtl/dfgc_out_if.sv
hw/rtl/dfgc_div.sv
hw/rtl/diamond_face_gradient_coeffs.sv
tb/diamond_face_gradient_coeffs_tb.sv
